FILE: src/pct_pkg.sv
// Package for the proximity contact table: item types, codes and defaults.
// Used by pct_entry_store and proximity_contact_table_core; depends on nothing.

package pct_pkg;

    // Default sizes of the table.
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_BYTES_DEF    = 8;
    localparam int HISTORY_LEN_DEF = 3;

    // Widths of the fixed item fields.
    localparam int ID_W    = 64;
    localparam int RANGE_W = 16;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIME     = 1'd1;
    localparam logic [CFG_DATA_W-1:0] NEAR_THRESHOLD_RST = 16'd3473;
    localparam logic [CFG_DATA_W-1:0] STALE_TIME_RST     = 16'd500;

    // Input operations and result kinds.
    localparam logic OP_REPORT   = 1'b0;
    localparam logic OP_LIST     = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_LIST   = 1'b1;

    // Verdict codes held in the history, two bits each.
    localparam logic [1:0] V_UNKNOWN = 2'd0;
    localparam logic [1:0] V_FAR     = 2'd1;
    localparam logic [1:0] V_NEAR    = 2'd2;

    typedef struct packed {
        logic               op;
        logic [ID_W-1:0]    peer_id;
        logic [RANGE_W-1:0] range_mm;
        logic [TIME_W-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic               stored;
        logic [SLOT_W-1:0]  slot;
        logic               is_confirmed;
        logic [ID_W-1:0]    contact_id;
        logic [COUNT_W-1:0] total_count;
        logic               last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

FILE: src/pct_entry_store.sv
// Entry memory of the proximity contact table, with one valid bit per entry.
// Depends on pct_pkg; instantiated by proximity_contact_table_core.

module pct_entry_store
    import pct_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int IDW         = 8 * ID_BYTES_DEF,
    parameter int HW          = 2 * HISTORY_LEN_DEF,
    parameter int IW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [IDW-1:0]    o_rd_id,
    output logic [TIME_W-1:0] o_rd_seen,
    output logic [HW-1:0]     o_rd_hist,
    output logic              o_rd_conf,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  logic [IDW-1:0]    i_wr_id,
    input  logic [TIME_W-1:0] i_wr_seen,
    input  logic [HW-1:0]     i_wr_hist,
    input  logic              i_wr_conf
);

    localparam int EW = IDW + TIME_W + HW + 1;

    logic [EW-1:0]          mem [MAX_ENTRIES];
    logic [EW-1:0]          r_rd_data;
    logic                   r_rd_vld;
    logic [MAX_ENTRIES-1:0] r_valid;

    // Entry array: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_id, i_wr_seen, i_wr_hist, i_wr_conf};
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Valid bits: an entry never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // Split the read word, forcing never-written entries to their reset value.
    assign o_rd_id   = r_rd_vld ? r_rd_data[EW-1 -: IDW]          : '0;
    assign o_rd_seen = r_rd_vld ? r_rd_data[HW+TIME_W : HW+1]     : '0;
    assign o_rd_hist = r_rd_vld ? r_rd_data[HW:1]                 : '0;
    assign o_rd_conf = r_rd_vld ? r_rd_data[0]                    : 1'b0;

endmodule

FILE: src/proximity_contact_table_core.sv
// Top level of the proximity contact table: control sequencer and output register.
// Depends on pct_pkg and pct_entry_store.
//
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_item) takes one item at a time:
// either a range report or a request to list confirmed contacts. The output
// channel (o_out_valid / i_out_ready / o_out_item) returns one result for a report
// and one result per confirmed slot for a list (a single empty result if none);
// the last result of an item has last set, and a list's last carries the count.
// Each item scans every table entry once through the entry memory, one read
// per cycle while the scan is not halted; a new item is taken only after the
// previous item's final result is loaded into the output register. The entry
// is written back at most once, at the end of a report, when a slot is found.
// Results wait in an output register; while it is full and not taken, a list
// scan halts at the next confirmed slot and a report halts in its final step.
// Reset clears every entry's valid bit at once, so the table reads as empty
// with no clearing pass; the registers return to threshold 3473 mm, stale 500 ms.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once.

module proximity_contact_table_core
    import pct_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int ID_BYTES    = ID_BYTES_DEF,
    parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDW = 8 * ID_BYTES;
    localparam int HW  = 2 * HISTORY_LEN;
    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    t_state              r_state, n_state;
    logic                r_op;
    logic [IDW-1:0]      r_id;
    logic [RANGE_W-1:0]  r_range;
    logic [TIME_W-1:0]   r_now;
    logic [CFG_DATA_W-1:0] r_near_thr;
    logic [CFG_DATA_W-1:0] r_stale;

    logic [IW-1:0]       r_addr;
    logic                r_issue_more;
    logic                r_chk_vld;
    logic [IW-1:0]       r_chk_idx;
    logic                r_match_found;
    logic [IW-1:0]       r_match_idx;
    logic [HW-1:0]       r_match_hist;
    logic                r_open_found;
    logic [IW-1:0]       r_open_idx;
    logic                r_have_pend;
    logic [IW-1:0]       r_pend_idx;
    logic [IDW-1:0]      r_pend_id;
    logic [CW-1:0]       r_count;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [IDW-1:0]      rd_id;
    logic [TIME_W-1:0]   rd_seen;
    logic [HW-1:0]       rd_hist;
    logic                rd_conf;

    logic                in_take;
    logic                out_free;
    logic                scan_adv;
    logic                rd_en;
    logic                list_hit;
    logic                out_load;
    t_out_item           out_data;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    logic [TIME_W-1:0]   age;
    logic                entry_open;
    logic [1:0]          verdict;
    logic [HW-1:0]       hist_old;
    logic [HW+1:0]       hist_shift;
    logic [HW-1:0]       hist_new;
    logic                conf_new;
    logic                found;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Entry memory.
    pct_entry_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDW         (IDW),
        .HW          (HW),
        .IW          (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_id   (rd_id),
        .o_rd_seen (rd_seen),
        .o_rd_hist (rd_hist),
        .o_rd_conf (rd_conf),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx),
        .i_wr_id   (r_id),
        .i_wr_seen (r_now),
        .i_wr_hist (hist_new),
        .i_wr_conf (conf_new)
    );

    // Staleness of the entry under check.
    assign age        = r_now - rd_seen;
    assign entry_open = (age > TIME_W'(r_stale)) && !rd_conf;

    // New history and confirmation for the chosen slot.
    assign found      = r_match_found || r_open_found;
    assign wr_idx     = r_match_found ? r_match_idx : r_open_idx;
    assign verdict    = (r_range < r_near_thr) ? V_NEAR : V_FAR;
    assign hist_old   = r_match_found ? r_match_hist : '0;
    assign hist_shift = {hist_old, verdict};
    assign hist_new   = hist_shift[HW-1:0];

    always_comb begin
        conf_new = 1'b1;
        for (int j = 0; j < HISTORY_LEN; j++) begin
            if (hist_new[2*j +: 2] != V_NEAR) begin
                conf_new = 1'b0;
            end
        end
    end

    // A confirmed slot found by a list scan while an earlier one is pending.
    assign list_hit = (r_state == ST_SCAN) && (r_op == OP_LIST) && r_chk_vld
                      && rd_conf && r_have_pend;

    // Next state and per-cycle controls.
    always_comb begin
        n_state  = r_state;
        scan_adv = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        out_data = '0;
        wr_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_adv = !(list_hit && !out_free);
                rd_en    = scan_adv && r_issue_more;
                if (list_hit && out_free) begin
                    out_load              = 1'b1;
                    out_data.kind         = KIND_LIST;
                    out_data.slot         = SLOT_W'(r_pend_idx);
                    out_data.is_confirmed = 1'b1;
                    out_data.contact_id   = ID_W'(r_pend_id);
                end
                if (!r_issue_more && !r_chk_vld) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    n_state       = ST_IDLE;
                    if (r_op == OP_LIST) begin
                        out_data.kind = KIND_LIST;
                        if (r_have_pend) begin
                            out_data.slot         = SLOT_W'(r_pend_idx);
                            out_data.is_confirmed = 1'b1;
                            out_data.contact_id   = ID_W'(r_pend_id);
                            out_data.total_count  = COUNT_W'(r_count);
                        end
                    end else begin
                        out_data.kind = KIND_REPORT;
                        if (found) begin
                            wr_en                 = 1'b1;
                            out_data.stored       = 1'b1;
                            out_data.slot         = SLOT_W'(wr_idx);
                            out_data.is_confirmed = conf_new;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_thr <= NEAR_THRESHOLD_RST;
            r_stale    <= STALE_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NEAR_THRESHOLD: r_near_thr <= i_cfg_data;
                CFG_STALE_TIME:     r_stale    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accepted item fields.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_in_item.op;
            r_id    <= i_in_item.peer_id[IDW-1:0];
            r_range <= i_in_item.range_mm;
            r_now   <= i_in_item.now_ms;
        end
    end

    // Scan address and check stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_issue_more <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_chk_idx    <= '0;
        end else if (in_take) begin
            r_addr       <= '0;
            r_issue_more <= 1'b1;
            r_chk_vld    <= 1'b0;
        end else if (scan_adv) begin
            r_chk_vld <= r_issue_more;
            if (r_issue_more) begin
                r_chk_idx <= r_addr;
                if (r_addr == LAST_IDX) begin
                    r_issue_more <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // Report scan: first matching live entry, and the last open one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found <= 1'b0;
            r_open_found  <= 1'b0;
        end else if (in_take) begin
            r_match_found <= 1'b0;
            r_open_found  <= 1'b0;
        end else if (scan_adv && r_chk_vld && (r_op == OP_REPORT)) begin
            if (entry_open) begin
                r_open_found <= 1'b1;
                r_open_idx   <= r_chk_idx;
            end else if ((rd_id == r_id) && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_chk_idx;
                r_match_hist  <= rd_hist;
            end
        end
    end

    // List scan: hold one confirmed slot back so the final one can carry last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pend <= 1'b0;
            r_count     <= '0;
        end else if (in_take) begin
            r_have_pend <= 1'b0;
            r_count     <= '0;
        end else if (scan_adv && r_chk_vld && (r_op == OP_LIST) && rd_conf) begin
            r_have_pend <= 1'b1;
            r_pend_idx  <= r_chk_idx;
            r_pend_id   <= rd_id;
            r_count     <= r_count + 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
